FILE: design/rsq_pkg.sv
// shared types and constants for the range sample qualifier
`default_nettype none

package rsq_pkg;

    localparam int unsigned RSQ_WINDOW = 4;
    localparam int unsigned DIST_W     = 16;
    localparam int unsigned LIMIT_W    = 8;

    localparam logic [DIST_W-1:0]  STOP_THRESHOLD_RST = 16'd20;
    localparam logic [DIST_W-1:0]  MAX_RANGE_RST      = 16'd400;
    localparam logic [DIST_W-1:0]  ERROR_MARKER_RST   = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST     = 8'd10;

    typedef enum logic [1:0] {
        CFG_STOP_THRESHOLD = 2'd0,
        CFG_MAX_RANGE      = 2'd1,
        CFG_ERROR_MARKER   = 2'd2,
        CFG_FAIL_LIMIT     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [DIST_W-1:0] raw_distance;
        logic              read_ok;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] mean_distance;
        logic              obstacle;
        logic              obstacle_entered;
        logic              obstacle_cleared;
        logic              sensor_fault;
    } t_out_item;

    typedef struct packed {
        logic [DIST_W-1:0] sample;
        logic              valid;
    } t_cell_data;

endpackage

`default_nettype wire

FILE: design/rsq_in_if.sv
// input channel: one rangefinder reading per transaction
`default_nettype none

interface rsq_in_if import rsq_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/rsq_out_if.sv
// output channel: one qualified result per transaction
`default_nettype none

interface rsq_out_if import rsq_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: design/rsq_cell.sv
// one sample cell of the window chain
`default_nettype none

module rsq_cell import rsq_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_shift,
    input  wire t_cell_data i_prev,
    output t_cell_data      o_data
);

    logic              r_valid;
    logic [DIST_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_prev.sample;
        end
    end

    assign o_data.sample = r_sample;
    assign o_data.valid  = r_valid;

endmodule

`default_nettype wire

FILE: design/rsq_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module rsq_divider import rsq_pkg::*; #(
    parameter int unsigned NUM_W = 18,
    parameter int unsigned DEN_W = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] w_trial;
    logic [DEN_W:0] w_diff;
    logic           w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire

FILE: design/range_sample_qualifier_unit.sv
// top level: reading qualifier, sample window chain, mean and status flags
//
//  channel  dir  signals                                 transaction when
//  i_in     in   valid, ready, data{raw_distance,read_ok} valid && ready
//  o_out    out  valid, ready, data{mean,flags}           valid && ready
//  i_cfg    in   i_cfg_we, i_cfg_index, i_cfg_data        i_cfg_we
//
//  the window sum rotates the chain once around, the mean takes one divider step per bit
//  one reading is in work at a time; i_in.ready is high only while the block waits
//  a finished result waits in the output register while the next reading is taken
//  reset is synchronous, active low, and empties the chain at once
`default_nettype none

module range_sample_qualifier_unit import rsq_pkg::*; #(
    parameter int unsigned WINDOW = RSQ_WINDOW
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    rsq_in_if.sink             i_in,
    rsq_out_if.source          o_out,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [DIST_W-1:0] i_cfg_data
);

    localparam int unsigned SUM_W  = DIST_W + $clog2(WINDOW);
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned STEP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ACCUM  = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    t_state             r_state;
    logic [DIST_W-1:0]  r_stop_threshold;
    logic [DIST_W-1:0]  r_max_range;
    logic [DIST_W-1:0]  r_error_marker;
    logic [LIMIT_W-1:0] r_fail_limit;
    logic [LIMIT_W-1:0] r_streak;
    logic               r_failed;
    logic               r_obst_prev;
    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_acc;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    t_out_item          r_out_data;

    t_cell_data         w_cell [WINDOW];
    t_cell_data         w_head;
    logic               w_shift;
    logic               w_accept;
    logic               w_bad;
    logic [DIST_W-1:0]  w_sample;
    logic [DIST_W-1:0]  w_addend;
    logic [SUM_W-1:0]   n_acc;
    logic               w_last_step;
    logic               w_div_start;
    logic               w_div_done;
    logic [SUM_W-1:0]   w_quot;
    logic [DIST_W-1:0]  w_mean;
    logic               w_obst;
    logic               w_out_free;
    logic [LIMIT_W-1:0] w_streak_inc;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_threshold <= STOP_THRESHOLD_RST;
            r_max_range      <= MAX_RANGE_RST;
            r_error_marker   <= ERROR_MARKER_RST;
            r_fail_limit     <= FAIL_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_STOP_THRESHOLD: r_stop_threshold <= i_cfg_data;
                CFG_MAX_RANGE:      r_max_range      <= i_cfg_data;
                CFG_ERROR_MARKER:   r_error_marker   <= i_cfg_data;
                CFG_FAIL_LIMIT:     r_fail_limit     <= i_cfg_data[LIMIT_W-1:0];
                default:            r_fail_limit     <= r_fail_limit;
            endcase
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_bad      = !i_in.data.read_ok || (i_in.data.raw_distance == r_error_marker);
    assign w_sample   = w_bad ? r_max_range : i_in.data.raw_distance;

    // window chain: insert shifts a new sample in, accumulation rotates it once around
    assign w_shift       = w_accept || (r_state == S_ACCUM);
    assign w_head.sample = (r_state == S_IDLE) ? w_sample : w_cell[WINDOW-1].sample;
    assign w_head.valid  = (r_state == S_IDLE) ? 1'b1 : w_cell[WINDOW-1].valid;

    for (genvar k = 0; k < WINDOW; k++) begin : g_cell
        rsq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_prev  ((k == 0) ? w_head : w_cell[(k == 0) ? 0 : k - 1]),
            .o_data  (w_cell[k])
        );
    end

    assign w_addend    = w_cell[WINDOW-1].valid ? w_cell[WINDOW-1].sample : '0;
    assign n_acc       = r_acc + SUM_W'(w_addend);
    assign w_last_step = (r_step == STEP_W'(WINDOW - 1));
    assign w_div_start = (r_state == S_ACCUM) && w_last_step;

    rsq_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (n_acc),
        .i_den   (r_count),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_mean       = w_quot[DIST_W-1:0];
    assign w_obst       = w_mean < r_stop_threshold;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_streak_inc = r_streak + LIMIT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_streak    <= '0;
            r_failed    <= 1'b0;
            r_obst_prev <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_ACCUM;
                        if (r_count != CNT_W'(WINDOW)) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (w_bad) begin
                            if (r_streak < r_fail_limit) begin
                                r_streak <= w_streak_inc;
                                if (w_streak_inc == r_fail_limit) begin
                                    r_failed <= 1'b1;
                                end
                            end
                        end else begin
                            r_streak <= '0;
                            r_failed <= 1'b0;
                        end
                    end
                end
                S_ACCUM: begin
                    if (w_last_step) begin
                        r_state <= S_DIVIDE;
                    end
                end
                S_DIVIDE: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_obst_prev <= w_obst;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc  <= '0;
            r_step <= '0;
        end else if (r_state == S_ACCUM) begin
            r_acc  <= n_acc;
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_data.mean_distance    <= w_mean;
            r_out_data.obstacle         <= w_obst;
            r_out_data.obstacle_entered <= w_obst && !r_obst_prev;
            r_out_data.obstacle_cleared <= !w_obst && r_obst_prev;
            r_out_data.sensor_fault     <= r_failed;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW))
        else $error("sample count above window");

    a_accept_to_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_ACCUM))
        else $error("accepted transaction did not start accumulation");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIVIDE))
        else $error("divider finished outside divide state");

    a_pulse_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.data.obstacle_entered && o_out.data.obstacle_cleared))
        else $error("obstacle entered and cleared together");

endmodule

`default_nettype wire
